// ----- rtl/delta_varint_record_decoder_assert.svh -----
// Assertion macros shared by the record decoder RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef DELTA_VARINT_RECORD_DECODER_ASSERT_SVH
`define DELTA_VARINT_RECORD_DECODER_ASSERT_SVH

// Same-cycle implication.
`define DVRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");

// Next-cycle implication.
`define DVRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

// ----- rtl/dvrd_pkg.sv -----
// Shared types, codes and constants for the delta varint record decoder.
// No dependencies; every RTL file refers to it by scoped names.
package dvrd_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned TILE_W        = 25;
  localparam logic [TILE_W-1:0] MAX_TILES = TILE_W'(MAX_DIMENSION * MAX_DIMENSION);
  localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_DELTA   = 3'd1,
    PH_OVERLAY = 3'd2,
    PH_LEVEL   = 3'd3,
    PH_OCC     = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_LONG     = 3'd2,
    ST_COUNT    = 3'd3,
    ST_DELTA    = 3'd4,
    ST_RANGE    = 3'd5,
    ST_OCC      = 3'd6,
    ST_OVERLAY  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    REG_TILE_COUNT    = 3'd0,
    REG_OVERLAY_LIMIT = 3'd1,
    REG_ZONE_CODE_A   = 3'd2,
    REG_ZONE_CODE_B   = 3'd3,
    REG_ZONE_CODE_C   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_count;
    logic [7:0]        overlay_limit;
    logic [7:0]        zone_code_a;
    logic [7:0]        zone_code_b;
    logic [7:0]        zone_code_c;
  } cfg_t;

  typedef struct packed {
    logic [23:0] tile_index;
    logic [7:0]  overlay_code;
    logic [1:0]  tile_level;
    logic [15:0] occupant_count;
    logic        last_record;
    status_t     status;
  } result_t;

endpackage

// ----- rtl/dvrd_varint.sv -----
// One LEB128 byte step: merges a byte into the partial value and flags the end.
// Uses dvrd_pkg for the length limit.
module dvrd_varint (
  input  logic [31:0] value,
  input  logic [2:0]  nbytes,
  input  logic [7:0]  data_byte,
  output logic [31:0] value_next,
  output logic        done,
  output logic        too_long
);

  logic [31:0] part;

  always_comb begin
    // Bits that land above bit 31 on the fifth byte are dropped.
    unique case (nbytes)
      3'd0:    part = {25'd0, data_byte[6:0]};
      3'd1:    part = {18'd0, data_byte[6:0], 7'd0};
      3'd2:    part = {11'd0, data_byte[6:0], 14'd0};
      3'd3:    part = {4'd0, data_byte[6:0], 21'd0};
      3'd4:    part = {data_byte[3:0], 28'd0};
      default: part = '0;
    endcase
    value_next = value | part;
    done       = !data_byte[7];
    too_long   = data_byte[7] && ((nbytes + 3'd1) >= dvrd_pkg::VARINT_MAX_BYTES);
  end

endmodule

// ----- rtl/dvrd_parser.sv -----
// Record parser state and the checks of one byte step, with a registered state update.
// Uses dvrd_pkg and dvrd_varint.
module dvrd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                list_start,
  input  dvrd_pkg::cfg_t      cfg,
  output logic                res_valid,
  output dvrd_pkg::result_t   res
);

  dvrd_pkg::phase_t         parse_phase, parse_phase_next, ph;
  logic [31:0]              varint_value, varint_value_next, vval;
  logic [2:0]               varint_bytes, varint_bytes_next, vbytes;
  logic [24:0]              records_left, records_left_next, left;
  logic                     first_record_flag, first_record_flag_next, first;
  logic [23:0]              previous_index, previous_index_next, prev;
  logic [7:0]               held_overlay, held_overlay_next, hov;
  logic [7:0]               held_level, held_level_next, hlev;

  logic [31:0]              sum;
  logic                     done, too_long;
  logic [24:0]              bound;
  logic [32:0]              idx;
  logic [24:0]              left_dec;
  logic                     zone;
  logic [1:0]               lvl;

  dvrd_varint u_varint (
    .value      (vval),
    .nbytes     (vbytes),
    .data_byte  (data_byte),
    .value_next (sum),
    .done       (done),
    .too_long   (too_long)
  );

  always_comb begin
    // A list start restarts the parser before this byte is taken.
    if (list_start) begin
      ph    = dvrd_pkg::PH_COUNT;
      vval  = '0;
      vbytes = '0;
      left  = '0;
      first = 1'b1;
      prev  = '0;
      hov   = '0;
      hlev  = '0;
    end else begin
      ph    = parse_phase;
      vval  = varint_value;
      vbytes = varint_bytes;
      left  = records_left;
      first = first_record_flag;
      prev  = previous_index;
      hov   = held_overlay;
      hlev  = held_level;
    end

    bound    = (cfg.tile_count > dvrd_pkg::MAX_TILES) ? dvrd_pkg::MAX_TILES : cfg.tile_count;
    idx      = {9'd0, prev} + {1'b0, sum};
    left_dec = left - 25'd1;
    zone     = (hov == cfg.zone_code_a) || (hov == cfg.zone_code_b) ||
               (hov == cfg.zone_code_c);
    if (hlev == 8'd0) begin
      lvl = 2'd1;
    end else if (hlev > 8'd3) begin
      lvl = 2'd3;
    end else begin
      lvl = hlev[1:0];
    end

    parse_phase_next       = ph;
    varint_value_next      = vval;
    varint_bytes_next      = vbytes;
    records_left_next      = left;
    first_record_flag_next = first;
    previous_index_next    = prev;
    held_overlay_next      = hov;
    held_level_next        = hlev;

    res_valid          = 1'b0;
    res.tile_index     = '0;
    res.overlay_code   = '0;
    res.tile_level     = '0;
    res.occupant_count = '0;
    res.last_record    = 1'b1;
    res.status         = dvrd_pkg::ST_OK;

    unique case (ph)
      dvrd_pkg::PH_COUNT, dvrd_pkg::PH_DELTA, dvrd_pkg::PH_OCC: begin
        varint_value_next = sum;
        varint_bytes_next = vbytes + 3'd1;
        if (too_long) begin
          res_valid = 1'b1;
          res.status = dvrd_pkg::ST_LONG;
        end else if (done) begin
          varint_value_next = '0;
          varint_bytes_next = '0;
          if (ph == dvrd_pkg::PH_COUNT) begin
            if (sum > {7'd0, bound}) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_COUNT;
            end else if (sum == 32'd0) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_EMPTY;
            end else begin
              records_left_next = sum[24:0];
              parse_phase_next  = dvrd_pkg::PH_DELTA;
            end
          end else if (ph == dvrd_pkg::PH_DELTA) begin
            if (!first && sum == 32'd0) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_DELTA;
            end else if (idx >= {8'd0, bound}) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_RANGE;
            end else begin
              previous_index_next    = idx[23:0];
              first_record_flag_next = 1'b0;
              parse_phase_next       = dvrd_pkg::PH_OVERLAY;
            end
          end else begin
            if (sum[31:16] != 16'd0) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_OCC;
            end else if (hov > cfg.overlay_limit) begin
              res_valid = 1'b1;
              res.status = dvrd_pkg::ST_OVERLAY;
            end else begin
              records_left_next  = left_dec;
              parse_phase_next   = (left_dec == 25'd0) ? dvrd_pkg::PH_IDLE : dvrd_pkg::PH_DELTA;
              res_valid          = 1'b1;
              res.tile_index     = prev;
              res.overlay_code   = hov;
              res.tile_level     = zone ? lvl : 2'd1;
              res.occupant_count = zone ? sum[15:0] : 16'd0;
              res.last_record    = (left_dec == 25'd0);
            end
          end
        end
        // Any error result parks the parser until the next list start.
        if (res_valid && res.status != dvrd_pkg::ST_OK) begin
          parse_phase_next = dvrd_pkg::PH_IDLE;
        end
      end
      dvrd_pkg::PH_OVERLAY: begin
        held_overlay_next = data_byte;
        parse_phase_next  = dvrd_pkg::PH_LEVEL;
      end
      dvrd_pkg::PH_LEVEL: begin
        held_level_next  = data_byte;
        parse_phase_next = dvrd_pkg::PH_OCC;
      end
      dvrd_pkg::PH_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= dvrd_pkg::PH_COUNT;
      varint_value      <= '0;
      varint_bytes      <= '0;
      records_left      <= '0;
      first_record_flag <= 1'b1;
      previous_index    <= '0;
      held_overlay      <= '0;
      held_level        <= '0;
    end else if (step) begin
      parse_phase       <= parse_phase_next;
      varint_value      <= varint_value_next;
      varint_bytes      <= varint_bytes_next;
      records_left      <= records_left_next;
      first_record_flag <= first_record_flag_next;
      previous_index    <= previous_index_next;
      held_overlay      <= held_overlay_next;
      held_level        <= held_level_next;
    end
  end

endmodule

// ----- rtl/delta_varint_record_decoder.sv -----
// Delta varint record decoder: a byte stream holding an LEB128 record count and
// records (LEB128 index delta, overlay byte, level byte, LEB128 occupant count) is
// turned into one word per finished record, or one error word, with absolute tile
// indices. Each accepted byte is registered, decoded combinationally by the parser and
// its result lands in an output register, so the block takes one byte per clock
// whenever the output side is not stalled; a result word is valid once the output
// register has taken it from the byte's input register. A byte with s_tuser set starts
// a new list; after reset no start mark is needed. After an error or the final
// record, bytes are dropped until the next start. A configuration write takes effect
// at once, so registers should be written only while no word is in flight.
// Depends on dvrd_pkg, dvrd_parser, dvrd_varint and the assertion macro header.
`include "delta_varint_record_decoder_assert.svh"

module delta_varint_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] list_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [23:0] tile_index, [31:24] overlay_code,
                                 // [33:32] tile_level, [49:34] occupant_count, zero pad
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,   // last_record
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_wdata
);

  dvrd_pkg::cfg_t    cfg;
  dvrd_pkg::result_t res, out_word;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_start;
  logic              advance;
  logic              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_count    <= 25'd65536;
      cfg.overlay_limit <= 8'd5;
      cfg.zone_code_a   <= 8'd2;
      cfg.zone_code_b   <= 8'd3;
      cfg.zone_code_c   <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dvrd_pkg::REG_TILE_COUNT:    cfg.tile_count    <= cfg_wdata;
        dvrd_pkg::REG_OVERLAY_LIMIT: cfg.overlay_limit <= cfg_wdata[7:0];
        dvrd_pkg::REG_ZONE_CODE_A:   cfg.zone_code_a   <= cfg_wdata[7:0];
        dvrd_pkg::REG_ZONE_CODE_B:   cfg.zone_code_b   <= cfg_wdata[7:0];
        dvrd_pkg::REG_ZONE_CODE_C:   cfg.zone_code_c   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // The held byte moves on once the output register can take its result.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  dvrd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .data_byte  (in_byte),
    .list_start (in_start),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tdata = {6'd0, out_word.occupant_count, out_word.tile_level,
                    out_word.overlay_code, out_word.tile_index};
  assign m_tuser = out_word.status;
  assign m_tlast = out_word.last_record;

  `DVRD_ASSERT_NEXT(a_hold_stalled_byte, in_valid && !advance, in_valid && $stable(in_byte))
  `DVRD_ASSERT_NOW(a_error_is_last, m_tvalid && m_tuser != dvrd_pkg::ST_OK, m_tlast)
  `DVRD_ASSERT_NOW(a_ok_level_nonzero, m_tvalid && m_tuser == dvrd_pkg::ST_OK, m_tdata[33:32] != 2'd0)
  `DVRD_ASSERT_NEXT(a_silent_step_clears, advance && !res_valid, !m_tvalid)

endmodule
